// ----- hw/rtl/svm_pkg.sv -----
// Package: shared constants and types for the sample voice mixer.
package svm_pkg;
   localparam int MaxVoices   = 16;
   localparam int NumSlots    = 16;
   localparam int MemWords    = 65536;
   localparam int VoiceW      = $clog2(MaxVoices);
   localparam int SlotW       = 4;
   localparam int AddrW       = $clog2(MemWords);
   localparam int CountW      = 5;
   localparam int AccW        = 40;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_DEFINE  = 2'd1;
   localparam logic [1:0] KIND_TRIGGER = 2'd2;
   localparam logic [1:0] KIND_TICK    = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [15:0]        address;
      logic signed [15:0] word_value;
      logic [3:0]         slot;
      logic [15:0]        frame_count;
      logic               is_stereo;
      logic [15:0]        voice_gain;
   } item_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic               accepted;
      logic [4:0]         active_voices;
   } result_type;
endpackage

// ----- hw/rtl/svm_queue.sv -----
// Two-entry queue between the front classifier and the back engine.
module svm_queue
   import svm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);
   item_type   mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_item;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// ----- hw/rtl/svm_engine.sv -----
// Back engine: memory, slot and voice tables, sequential tick mixer.
module svm_engine
   import svm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOOK = 5'b00010,
      ST_RDL  = 5'b00100,
      ST_MAC  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   logic signed [15:0] mem [MemWords];
   logic signed [15:0] rd_data_ff;

   logic [NumSlots-1:0]  s_valid_ff;
   logic [15:0]          s_start_ff  [NumSlots];
   logic [15:0]          s_frames_ff [NumSlots];
   logic                 s_stereo_ff [NumSlots];

   logic [MaxVoices-1:0] v_active_ff;
   logic [SlotW-1:0]     v_slot_ff [MaxVoices];
   logic [15:0]          v_pos_ff  [MaxVoices];
   logic [15:0]          v_gain_ff [MaxVoices];

   state_type          state_ff;
   logic [VoiceW-1:0]  vi_ff;
   logic               last_ff;
   logic               chan_ff;     // 0 left read, 1 right read
   logic               mono_ff;
   logic [AddrW-1:0]   rd_addr_ff;
   logic [AddrW-1:0]   addr2_ff;
   logic signed [AccW-1:0] accl_ff, accr_ff;
   logic signed [15:0] sl_ff;
   logic               ov_ff;
   result_type         res_ff;

   // trigger: lowest free voice
   logic [VoiceW-1:0] free_idx;
   logic              free_any;
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = MaxVoices - 1; i >= 0; i--) begin
         if (!v_active_ff[i]) begin
            free_idx = VoiceW'(i);
            free_any = 1'b1;
         end
      end
   end

   logic [CountW-1:0] act_cnt;
   always_comb begin
      act_cnt = '0;
      for (int i = 0; i < MaxVoices; i++) act_cnt = act_cnt + CountW'(v_active_ff[i]);
   end

   function automatic logic signed [15:0] sat_round(input logic signed [AccW-1:0] a);
      logic signed [AccW-1:0] t;
      logic signed [AccW-15:0] q;
      t = a + AccW'(8192);
      q = t[AccW-1:14];
      if (q > 32767) return 16'sh7fff;
      else if (q < -32768) return 16'sh8000;
      else return q[15:0];
   endfunction

   // current voice view
   logic [SlotW-1:0] cs;
   logic [15:0]      cpos;
   logic             cexp;
   logic [16:0]      p2;
   assign cs   = v_slot_ff[vi_ff];
   assign cpos = v_pos_ff[vi_ff];
   assign cexp = (cpos >= s_frames_ff[cs]);
   assign p2   = {cpos, 1'b0};

   logic signed [32:0] prod;
   assign prod = rd_data_ff * $signed({1'b0, v_gain_ff[vi_ff]});

   assign in_ready  = (state_ff == ST_IDLE) && !ov_ff;
   assign out_valid = ov_ff;
   assign out_result = res_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr_ff];
      if (in_valid && in_ready && in_item.kind == KIND_LOAD)
         mem[in_item.address] <= in_item.word_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ov_ff       <= 1'b0;
         s_valid_ff  <= '0;
         v_active_ff <= '0;
      end else begin
         if (ov_ff && out_ready) ov_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (in_valid && in_ready) begin
                  res_ff.left_out  <= '0;
                  res_ff.right_out <= '0;
                  res_ff.accepted  <= 1'b1;
                  case (in_item.kind)
                     KIND_LOAD: begin
                        res_ff.active_voices <= act_cnt;
                        ov_ff <= 1'b1;
                     end
                     KIND_DEFINE: begin
                        s_valid_ff[in_item.slot]  <= 1'b1;
                        s_start_ff[in_item.slot]  <= in_item.address;
                        s_frames_ff[in_item.slot] <= in_item.frame_count;
                        s_stereo_ff[in_item.slot] <= in_item.is_stereo;
                        res_ff.active_voices <= act_cnt;
                        ov_ff <= 1'b1;
                     end
                     KIND_TRIGGER: begin
                        if (s_valid_ff[in_item.slot] && free_any) begin
                           v_active_ff[free_idx] <= 1'b1;
                           v_slot_ff[free_idx]   <= in_item.slot;
                           v_pos_ff[free_idx]    <= '0;
                           v_gain_ff[free_idx]   <= in_item.voice_gain;
                           res_ff.active_voices  <= act_cnt + CountW'(1);
                        end else begin
                           res_ff.accepted      <= 1'b0;
                           res_ff.active_voices <= act_cnt;
                        end
                        ov_ff <= 1'b1;
                     end
                     default: begin
                        vi_ff   <= '0;
                        last_ff <= 1'b0;
                        accl_ff <= '0;
                        accr_ff <= '0;
                        state_ff <= ST_LOOK;
                     end
                  endcase
               end
            end
            ST_LOOK: begin
               // inspect voice vi_ff; issue read if it plays
               if (!v_active_ff[vi_ff]) begin
                  if (last_ff) state_ff <= ST_DONE;
                  else begin
                     vi_ff <= vi_ff + VoiceW'(1);
                     last_ff <= (vi_ff == VoiceW'(MaxVoices - 2));
                  end
               end else if (cexp) begin
                  v_active_ff[vi_ff] <= 1'b0;
                  if (last_ff) state_ff <= ST_DONE;
                  else begin
                     vi_ff <= vi_ff + VoiceW'(1);
                     last_ff <= (vi_ff == VoiceW'(MaxVoices - 2));
                  end
               end else begin
                  mono_ff <= !s_stereo_ff[cs];
                  if (s_stereo_ff[cs]) begin
                     rd_addr_ff <= AddrW'(s_start_ff[cs] + p2[15:0]);
                     addr2_ff   <= AddrW'(s_start_ff[cs] + p2[15:0] + 16'd1);
                  end else
                     rd_addr_ff <= AddrW'(s_start_ff[cs] + cpos);
                  chan_ff  <= 1'b0;
                  state_ff <= ST_RDL;
               end
            end
            ST_RDL: begin
               // address registered; wait for read data
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               if (!chan_ff) begin
                  accl_ff <= accl_ff + AccW'(prod);
                  if (mono_ff) accr_ff <= accr_ff + AccW'(prod);
               end else
                  accr_ff <= accr_ff + AccW'(prod);
               if (!chan_ff && !mono_ff) begin
                  rd_addr_ff <= addr2_ff;
                  chan_ff    <= 1'b1;
                  state_ff   <= ST_RDL;
               end else begin
                  v_pos_ff[vi_ff] <= cpos + 16'd1;
                  if ((cpos + 16'd1) >= s_frames_ff[cs]) v_active_ff[vi_ff] <= 1'b0;
                  if (last_ff) state_ff <= ST_DONE;
                  else begin
                     vi_ff <= vi_ff + VoiceW'(1);
                     last_ff <= (vi_ff == VoiceW'(MaxVoices - 2));
                     state_ff <= ST_LOOK;
                  end
               end
            end
            ST_DONE: begin
               res_ff.left_out      <= sat_round(accl_ff);
               res_ff.right_out     <= sat_round(accr_ff);
               res_ff.accepted      <= 1'b1;
               res_ff.active_voices <= act_cnt;
               ov_ff    <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// ----- hw/rtl/svm_front.sv -----
// Front: unpacks input transfers into items and registers them; drops nothing.
module svm_front
   import svm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        s_tvalid,
   output logic        s_tready,
   input  logic [71:0] s_tdata,
   input  logic [1:0]  s_tuser,
   output logic        q_valid,
   input  logic        q_ready,
   output item_type    q_item
);
   logic     full_ff;
   item_type item_ff;
   item_type item_in;

   always_comb begin
      item_in.kind        = s_tuser;
      item_in.address     = s_tdata[15:0];
      item_in.word_value  = s_tdata[31:16];
      item_in.slot        = s_tdata[35:32];
      item_in.frame_count = s_tdata[51:36];
      item_in.is_stereo   = s_tdata[52];
      item_in.voice_gain  = s_tdata[68:53];
   end

   assign s_tready = !full_ff || q_ready;
   assign q_valid  = full_ff;
   assign q_item   = item_ff;

   always_ff @(posedge clock) begin
      if (s_tvalid && s_tready) item_ff <= item_in;
      if (reset) full_ff <= 1'b0;
      else if (s_tvalid && s_tready) full_ff <= 1'b1;
      else if (q_ready) full_ff <= 1'b0;
   end
endmodule

// ----- hw/rtl/sample_voice_mixer.sv -----
// Top level of the sample voice mixer.
// Usage:
//   Input channel req_*: one transfer per item. req_tuser is the item kind
//   (load word, define slot, trigger voice, frame tick); req_tdata packs the
//   other fields. Result channel rsp_*: exactly one transfer per item, in order,
//   carrying left/right mix, accepted flag and the active voice count.
// Flow:
//   Load, define and trigger pass the front register, the queue and the engine
//   result register on their way from request transfer to result transfer.
//   A frame tick walks the 16 voice entries in turn; each playing voice adds a
//   read wait and a multiply-accumulate step per sample word (one word for a
//   mono voice, two for a stereo voice) from the sample memory, and a final
//   step rounds the sums. A register stage and a two-entry queue let new items
//   arrive while the engine works.
// Reset: synchronous, active high; clears slot valid bits, voice active bits
//   and all handshake state. Sample memory is not cleared.
// Stall: when rsp_tready is low the result is held; the engine then stops,
//   the queue fills and req_tready drops.
module sample_voice_mixer
   import svm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // address[15:0], word_value[31:16], slot[35:32], frame_count[51:36],
   // is_stereo[52], voice_gain[68:53], zero fill
   input  logic [71:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // left_out[15:0], right_out[31:16], accepted[32], active_voices[37:33], zero fill
   output logic [39:0] rsp_tdata
);
   logic       f_valid, f_ready, q_valid, q_ready;
   item_type   f_item, q_item;
   result_type res;

   svm_front u_front (
      .clock, .reset,
      .s_tvalid(req_tvalid), .s_tready(req_tready),
      .s_tdata(req_tdata), .s_tuser(req_tuser),
      .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
   );

   svm_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   svm_engine u_engine (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res)
   );

   assign rsp_tdata = {2'b00, res.active_voices, res.accepted, res.right_out, res.left_out};
endmodule

// ----- tb/sample_voice_mixer_test.sv -----
// Self-checking testbench for the sample voice mixer: directed cases, then random traffic.
module sample_voice_mixer_test;
   import svm_pkg::*;

   // Sample memory region that is written before any voice plays. It wraps around
   // the top of the address space; every slot but the long one in test_long_slot lies inside it.
   localparam int RegionBase = 65280;
   localparam int RegionLen  = 768;
   localparam int WatchLimit = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   sample_voice_mixer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Mirror of the mixer state
   logic signed [15:0] mem_img [int];
   bit                 slot_ok    [NumSlots];
   logic [15:0]        slot_start [NumSlots];
   logic [15:0]        slot_len   [NumSlots];
   bit                 slot_st    [NumSlots];
   bit                 voice_on   [MaxVoices];
   logic [3:0]         voice_slot [MaxVoices];
   int unsigned        voice_pos  [MaxVoices];
   logic [15:0]        voice_gain [MaxVoices];

   result_type pending_mix [$];
   int         errors;
   int         n_sent;
   int         n_ticks;
   int         n_rejects;
   int         n_checked;
   int         idle_cycles;
   bit         no_gaps;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic signed [15:0] mem_word(int unsigned a);
      int key;
      key = a % MemWords;
      return mem_img.exists(key) ? mem_img[key] : 16'sd0;
   endfunction

   function automatic logic signed [15:0] round_sat(longint acc);
      longint q;
      q = (acc + 8192) >>> 14;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   // Applies one item to the mirror and returns the result it must produce.
   function automatic result_type mix_item(item_type it);
      result_type r;
      longint     accl, accr;
      longint     sl, sr;
      int         s;
      int unsigned base;
      int         n;
      r = '0;
      r.accepted = 1'b1;
      case (it.kind)
         KIND_LOAD: mem_img[it.address] = it.word_value;
         KIND_DEFINE: begin
            slot_ok[it.slot]    = 1'b1;
            slot_start[it.slot] = it.address;
            slot_len[it.slot]   = it.frame_count;
            slot_st[it.slot]    = it.is_stereo;
         end
         KIND_TRIGGER: begin
            r.accepted = 1'b0;
            if (slot_ok[it.slot]) begin
               for (int i = 0; i < MaxVoices; i++) begin
                  if (!voice_on[i]) begin
                     voice_on[i]   = 1'b1;
                     voice_slot[i] = it.slot;
                     voice_pos[i]  = 0;
                     voice_gain[i] = it.voice_gain;
                     r.accepted    = 1'b1;
                     break;
                  end
               end
            end
         end
         default: begin
            accl = 0;
            accr = 0;
            for (int i = 0; i < MaxVoices; i++) begin
               if (!voice_on[i]) continue;
               s = voice_slot[i];
               if (voice_pos[i] >= slot_len[s]) begin
                  voice_on[i] = 1'b0;
                  continue;
               end
               if (slot_st[s]) begin
                  base = slot_start[s] + 2 * voice_pos[i];
                  sl = mem_word(base);
                  sr = mem_word(base + 1);
               end else begin
                  sl = mem_word(slot_start[s] + voice_pos[i]);
                  sr = sl;
               end
               accl += sl * longint'(voice_gain[i]);
               accr += sr * longint'(voice_gain[i]);
               voice_pos[i]++;
               if (voice_pos[i] >= slot_len[s]) voice_on[i] = 1'b0;
            end
            r.left_out  = round_sat(accl);
            r.right_out = round_sat(accr);
         end
      endcase
      n = 0;
      for (int i = 0; i < MaxVoices; i++) n += voice_on[i];
      r.active_voices = n[4:0];
      return r;
   endfunction

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Sends one item; the expectation is queued at the accepting edge.
   task automatic send_item(item_type it);
      int gap;
      result_type r;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {3'b0, it.voice_gain, it.is_stereo, it.frame_count, it.slot,
                     it.word_value, it.address};
      do @(posedge clock); while (!req_tready);
      r = mix_item(it);
      pending_mix = {pending_mix, r};
      n_sent++;
      if (it.kind == KIND_TICK) n_ticks++;
      if (!r.accepted) n_rejects++;
   endtask

   // Item with random filler in every field the kind ignores.
   function automatic item_type noise_item(logic [1:0] kind);
      item_type it;
      it.kind        = kind;
      it.address     = 16'($urandom);
      it.word_value  = 16'($urandom);
      it.slot        = 4'($urandom);
      it.frame_count = 16'($urandom);
      it.is_stereo   = 1'($urandom);
      it.voice_gain  = 16'($urandom);
      return it;
   endfunction

   task automatic send_load(int unsigned addr, logic signed [15:0] w);
      item_type it;
      it = noise_item(KIND_LOAD);
      it.address    = 16'(addr);
      it.word_value = w;
      send_item(it);
   endtask

   task automatic send_define(int sl, int unsigned start, int unsigned len, bit st);
      item_type it;
      it = noise_item(KIND_DEFINE);
      it.slot        = 4'(sl);
      it.address     = 16'(start);
      it.frame_count = 16'(len);
      it.is_stereo   = st;
      send_item(it);
   endtask

   task automatic send_trigger(int sl, int unsigned g);
      item_type it;
      it = noise_item(KIND_TRIGGER);
      it.slot       = 4'(sl);
      it.voice_gain = 16'(g);
      send_item(it);
   endtask

   task automatic send_tick();
      send_item(noise_item(KIND_TICK));
   endtask

   // Slot placement that only touches the written region.
   task automatic define_in_region(int sl, bit st, int maxlen);
      int off, room, len;
      off  = $urandom_range(0, RegionLen - 1);
      room = st ? (RegionLen - off) / 2 : RegionLen - off;
      if (room > maxlen) room = maxlen;
      len = $urandom_range(0, room);
      send_define(sl, (RegionBase + off) % MemWords, len, st);
   endtask

   task automatic test_preload();
      for (int i = 0; i < RegionLen; i++)
         send_load((RegionBase + i) % MemWords, 16'($urandom));
   endtask

   task automatic test_edges();
      // trigger on a slot that was never defined
      send_trigger(15, 16'h4000);
      send_load(16'hFFFF, 16'sh7FFF);
      send_load(16'h0000, -16'sd32768);
      send_load(16'h0001, 16'sh7FFF);
      // zero-length sample: accepted, freed on the next tick
      send_define(1, 0, 0, 1'b0);
      send_trigger(1, 16'hFFFF);
      send_tick();
      // stereo pair that wraps the top address, full gain
      send_define(3, 16'hFFFF, 1, 1'b1);
      send_trigger(3, 16'hFFFF);
      send_trigger(3, 16'hFFFF);
      send_tick();
      // saturation in both directions
      send_define(4, 0, 2, 1'b0);
      send_trigger(4, 16'hFFFF);
      send_trigger(4, 16'h0000);
      send_tick();
      send_tick();
   endtask

   task automatic test_voices_full();
      send_define(0, 16'h0001, RegionLen - 256 - 1, 1'b0);
      for (int i = 0; i <= MaxVoices; i++) send_trigger(0, 16'hFFFF);
      send_tick();
      // shrinking the slot under the playing voices frees them all
      send_define(0, 16'h0001, 0, 1'b0);
      send_tick();
   endtask

   task automatic test_long_slot();
      send_define(2, RegionBase, 16'hFFFF, 1'b0);
      send_trigger(2, 16'h2000);
      repeat (3) send_tick();
      send_define(2, RegionBase, 1, 1'b1);
      send_tick();
   endtask

   task automatic test_random(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         if (i % 400 == 200) no_gaps = 1'b1;
         if (i % 400 == 300) no_gaps = 1'b0;
         r = $urandom_range(0, 99);
         if (r < 20) begin
            if ($urandom_range(0, 1)) send_load($urandom, 16'($urandom));
            else send_load((RegionBase + $urandom_range(0, RegionLen - 1)) % MemWords,
                           16'($urandom));
         end else if (r < 33) begin
            define_in_region($urandom_range(0, NumSlots - 1), 1'($urandom_range(0, 1)),
                             ($urandom_range(0, 9) == 0) ? RegionLen : 24);
         end else if (r < 58) begin
            send_trigger($urandom_range(0, NumSlots - 1), $urandom);
         end else begin
            send_tick();
         end
      end
   endtask

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   // Result side: random backpressure, one check per transfer.
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (!no_gaps && $urandom_range(0, 7) == 0) begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(1, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      result_type exp_r, act_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act_r.left_out      = rsp_tdata[15:0];
         act_r.right_out     = rsp_tdata[31:16];
         act_r.accepted      = rsp_tdata[32];
         act_r.active_voices = rsp_tdata[37:33];
         if (pending_mix.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transfer, actual %h", $time, rsp_tdata);
         end else begin
            exp_r = pending_mix.pop_front();
            n_checked++;
            check_field("left_out", exp_r.left_out, act_r.left_out);
            check_field("right_out", exp_r.right_out, act_r.right_out);
            check_field("accepted", exp_r.accepted, act_r.accepted);
            check_field("active_voices", exp_r.active_voices, act_r.active_voices);
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("%0t: no transfer for %0d cycles", $time, WatchLimit);
         $display("sample_voice_mixer regression: fail");
         $finish;
      end
   end

   initial begin
      errors = 0;
      n_sent = 0;
      n_ticks = 0;
      n_rejects = 0;
      n_checked = 0;
      idle_cycles = 0;
      no_gaps = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_LOAD;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_preload();
      test_edges();
      test_voices_full();
      test_long_slot();
      test_random(1200);

      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_mix.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d items (%0d frame ticks, %0d rejected), checked %0d results.",
               n_sent, n_ticks, n_rejects, n_checked);
      $display("Covered loads, slot defines, voice triggers, saturation and full voice table.");
      if (errors == 0)
         $display("sample_voice_mixer regression: pass");
      else
         $display("sample_voice_mixer regression: fail");
      $finish;
   end
endmodule
